// ===== src/fgb_pkg.sv =====
`timescale 1ns / 1ps

package fgb_pkg;

    localparam int SHEET_WIDTH = 128;
    localparam int GLYPH_SIZE  = 8;
    localparam int SHEET_DEPTH = 16384;
    localparam int SHEET_AW    = $clog2(SHEET_DEPTH);
    localparam int BANKS       = 8;
    localparam int BANK_SEL_W  = $clog2(BANKS);
    localparam int BANK_AW     = SHEET_AW - BANK_SEL_W;
    localparam int BANK_DEPTH  = SHEET_DEPTH / BANKS;

    localparam logic [7:0] BLANK_CODE    = 8'd32;
    localparam logic [7:0] BLANK_CODE_HI = 8'd160;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    localparam logic [1:0] REG_SCREEN_HEIGHT     = 2'd0;
    localparam logic [1:0] REG_ROW_PITCH         = 2'd1;
    localparam logic [1:0] REG_FRAME_BASE        = 2'd2;
    localparam logic [1:0] REG_TRANSPARENT_COLOR = 2'd3;

    typedef struct packed {
        logic                en;
        logic [SHEET_AW-1:0] addr;
        logic [7:0]          data;
    } sheet_wr_t;

    typedef struct packed {
        logic                en;
        logic [SHEET_AW-1:0] addr;
    } sheet_rd_t;

endpackage

// ===== src/font_glyph_blit_8x8.sv =====
`timescale 1ns / 1ps

// 8x8 glyph blitter over a 128x128 byte font sheet (16x16 glyphs). A load
// transfer writes one sheet byte. A draw transfer emits one result per
// visible glyph row, top first: the framebuffer byte address, the eight
// pixel bytes and a mask of the non-transparent bytes, with last_row on the
// final row. Blank codes, glyphs wholly off the top and glyphs that run past
// the bottom of the screen give no result and leave the input ready. A
// visible draw first runs the setup states S_MUL and S_ADD, where one shared
// 32-bit adder forms frame_base + x + line * row_pitch, and then one row per
// cycle while the output is taken; the same adder steps the address by
// row_pitch per row, and the banked sheet delivers all eight bytes of a row
// in one read. The input is not ready until the last row sits in the output
// register. Never-loaded sheet bytes read as undefined.
module font_glyph_blit_8x8 (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [11:0] s_x,
    input  logic [11:0] s_y,
    input  logic [7:0]  s_char_code,
    input  logic [13:0] s_font_address,
    input  logic [7:0]  s_font_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_row_address,
    output logic [63:0] m_row_pixels,
    output logic [7:0]  m_write_mask,
    output logic        m_last_row
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_ADD  = 2'd2;
    localparam logic [1:0] S_ROW  = 2'd3;

    localparam int AW = fgb_pkg::SHEET_AW;

    // configuration
    logic [12:0] screen_height_reg;
    logic [13:0] row_pitch_reg;
    logic [31:0] frame_base_reg;
    logic [7:0]  transparent_color_reg;

    logic [1:0]    state_reg, state_next;
    logic [10:0]   line_reg;
    logic [11:0]   x_reg;
    logic [24:0]   prod_reg;
    logic [31:0]   addr_reg;
    logic [AW-1:0] src_reg;
    logic [2:0]    rows_left_reg;

    logic          m_valid_reg;
    logic [31:0]   row_address_reg;
    logic [63:0]   row_pixels_reg;
    logic [7:0]    write_mask_reg;
    logic          last_row_reg;

    logic          in_xfer;
    logic          draw_go;
    logic          y_neg;
    logic [2:0]    skip;
    logic [13:0]   y_bottom;
    logic [AW-1:0] src_start;
    logic          out_free;
    logic          row_load;
    logic [31:0]   add_a, add_b, add_sum;
    logic [AW-1:0] src_step;
    logic [63:0]   pixels;
    logic [7:0]    mask;

    fgb_pkg::sheet_wr_t sheet_wr;
    fgb_pkg::sheet_rd_t sheet_rd;

    assign s_ready = (state_reg == S_IDLE);
    assign in_xfer = s_valid && s_ready;

    // draw decisions on the incoming item
    assign y_neg    = s_y[11];
    assign skip     = 3'(~s_y[2:0] + 3'd1);
    assign y_bottom = 14'({{2{s_y[11]}}, s_y} + 14'sd8);
    assign draw_go  = (s_op == fgb_pkg::OP_DRAW)
        && (s_char_code != fgb_pkg::BLANK_CODE)
        && (s_char_code != fgb_pkg::BLANK_CODE_HI)
        && !($signed(s_y) <= -12'sd8)
        && ($signed(y_bottom) <= $signed({1'b0, screen_height_reg}));

    assign src_start = AW'(
        32'(s_char_code[7:4]) * 32'(fgb_pkg::GLYPH_SIZE * fgb_pkg::SHEET_WIDTH)
        + 32'(s_char_code[3:0]) * 32'(fgb_pkg::GLYPH_SIZE)
        + 32'(y_neg ? skip : 3'd0) * 32'(fgb_pkg::SHEET_WIDTH));

    assign src_step = src_reg + AW'(fgb_pkg::SHEET_WIDTH);

    assign out_free = !m_valid_reg || m_ready;
    assign row_load = (state_reg == S_ROW) && out_free;

    // shared address adder
    always_comb begin
        case (state_reg)
            S_MUL: begin
                add_a = frame_base_reg;
                add_b = 32'(x_reg);
            end
            S_ADD: begin
                add_a = addr_reg;
                add_b = 32'(prod_reg);
            end
            default: begin
                add_a = addr_reg;
                add_b = 32'(row_pitch_reg);
            end
        endcase
        add_sum = add_a + add_b;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_xfer && draw_go) state_next = S_MUL;
            S_MUL:  state_next = S_ADD;
            S_ADD:  state_next = S_ROW;
            S_ROW:  if (row_load && rows_left_reg == 3'd0) state_next = S_IDLE;
        endcase
    end

    assign sheet_wr.en   = in_xfer && (s_op == fgb_pkg::OP_LOAD);
    assign sheet_wr.addr = s_font_address;
    assign sheet_wr.data = s_font_byte;

    // first row read at the end of setup, next row read as each row leaves
    assign sheet_rd.en   = (state_reg == S_ADD) || (row_load && rows_left_reg != 3'd0);
    assign sheet_rd.addr = (state_reg == S_ADD) ? src_reg : src_step;

    fgb_sheet u_sheet (
        .aclk      (aclk),
        .wr        (sheet_wr),
        .rd        (sheet_rd),
        .rd_pixels (pixels)
    );

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            mask[i] = (pixels[8*i +: 8] != transparent_color_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_height_reg     <= 13'd480;
            row_pitch_reg         <= 14'd640;
            frame_base_reg        <= 32'd0;
            transparent_color_reg <= 8'd255;
        end else if (cfg_we) begin
            unique case (cfg_index)
                fgb_pkg::REG_SCREEN_HEIGHT:     screen_height_reg     <= cfg_data[12:0];
                fgb_pkg::REG_ROW_PITCH:         row_pitch_reg         <= cfg_data[13:0];
                fgb_pkg::REG_FRAME_BASE:        frame_base_reg        <= cfg_data;
                fgb_pkg::REG_TRANSPARENT_COLOR: transparent_color_reg <= cfg_data[7:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (row_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer && draw_go) begin
            line_reg      <= y_neg ? 11'd0 : s_y[10:0];
            x_reg         <= s_x;
            src_reg       <= src_start;
            rows_left_reg <= y_neg ? 3'(3'd7 - skip) : 3'd7;
        end
        if (state_reg == S_MUL) begin
            prod_reg <= 25'(line_reg) * 25'(row_pitch_reg);
        end
        if (state_reg == S_MUL || state_reg == S_ADD || row_load) begin
            addr_reg <= add_sum;
        end
        if (row_load) begin
            row_address_reg <= addr_reg;
            row_pixels_reg  <= pixels;
            write_mask_reg  <= mask;
            last_row_reg    <= (rows_left_reg == 3'd0);
            src_reg         <= src_step;
            rows_left_reg   <= rows_left_reg - 3'd1;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_row_address = row_address_reg;
    assign m_row_pixels  = row_pixels_reg;
    assign m_write_mask  = write_mask_reg;
    assign m_last_row    = last_row_reg;

    // a draw only finishes by putting its final row in the output register
    a_last_row_on_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROW && state_next == S_IDLE) |=> (m_valid_reg && last_row_reg))
        else $error("draw finished without a last row result");

    // blank codes never start a draw
    a_blank_no_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && s_op == fgb_pkg::OP_DRAW
            && (s_char_code == fgb_pkg::BLANK_CODE || s_char_code == fgb_pkg::BLANK_CODE_HI))
        |=> (state_reg == S_IDLE))
        else $error("blank code started a draw");

    // setup always runs through both adder steps before rows
    a_setup_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MUL) |=> (state_reg == S_ADD) ##1 (state_reg == S_ROW))
        else $error("setup sequence broken");

    // rows are only produced while a draw is in progress
    a_rows_in_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        (!$past(m_valid_reg) && m_valid_reg) |-> ($past(state_reg) == S_ROW))
        else $error("result appeared outside a draw");

endmodule

// ===== src/fgb_sheet.sv =====
`timescale 1ns / 1ps

// font sheet split into eight byte banks so any eight consecutive bytes
// come out in one read, rotated back into pixel order
module fgb_sheet (
    input  logic                aclk,
    input  fgb_pkg::sheet_wr_t  wr,
    input  fgb_pkg::sheet_rd_t  rd,
    output logic [63:0]         rd_pixels
);

    logic [7:0]                       bank_q_reg [fgb_pkg::BANKS];
    logic [fgb_pkg::BANK_SEL_W-1:0]   rot_reg;

    genvar b;
    generate
        for (b = 0; b < fgb_pkg::BANKS; b++) begin : g_bank
            logic [7:0]                    mem [fgb_pkg::BANK_DEPTH];
            logic [fgb_pkg::BANK_AW-1:0]   rd_word;

            // bytes below the start offset belong to the next word
            assign rd_word = rd.addr[fgb_pkg::SHEET_AW-1:fgb_pkg::BANK_SEL_W]
                + fgb_pkg::BANK_AW'(
                    (fgb_pkg::BANK_SEL_W'(b) < rd.addr[fgb_pkg::BANK_SEL_W-1:0]));

            always_ff @(posedge aclk) begin
                if (wr.en && wr.addr[fgb_pkg::BANK_SEL_W-1:0] == fgb_pkg::BANK_SEL_W'(b)) begin
                    mem[wr.addr[fgb_pkg::SHEET_AW-1:fgb_pkg::BANK_SEL_W]] <= wr.data;
                end
                if (rd.en) begin
                    bank_q_reg[b] <= mem[rd_word];
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rot_reg <= rd.addr[fgb_pkg::BANK_SEL_W-1:0];
        end
    end

    always_comb begin
        logic [fgb_pkg::BANK_SEL_W-1:0] sel;
        for (int i = 0; i < fgb_pkg::BANKS; i++) begin
            sel = rot_reg + fgb_pkg::BANK_SEL_W'(i);
            rd_pixels[8*i +: 8] = bank_q_reg[sel];
        end
    end

endmodule
